/* rtl/core/ssti_pkg.sv */
// ----------------------------------------------------------------------------
// ssti_pkg
// Shared constants and types for the swept sphere time of impact core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssti_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int STEP_RESET    = 1092;

    // Control that travels alongside each request through the pipeline.
    typedef struct packed {
        logic valid;
        logic ok;
    } ssti_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/ssti_if.sv */
// ----------------------------------------------------------------------------
// ssti_in_if / ssti_out_if
// Valid/ready channels for requests into and results out of the core.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssti_in_if #(
    parameter int WORD_BITS = 32
);
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] rel_pos_x;
    logic signed [WORD_BITS-1:0] rel_pos_y;
    logic signed [WORD_BITS-1:0] rel_pos_z;
    logic signed [WORD_BITS-1:0] rel_vel_x;
    logic signed [WORD_BITS-1:0] rel_vel_y;
    logic signed [WORD_BITS-1:0] rel_vel_z;
    logic        [WORD_BITS-2:0] contact_radius;

    modport source (
        output valid, rel_pos_x, rel_pos_y, rel_pos_z,
        output rel_vel_x, rel_vel_y, rel_vel_z, contact_radius,
        input  ready
    );
    modport sink (
        input  valid, rel_pos_x, rel_pos_y, rel_pos_z,
        input  rel_vel_x, rel_vel_y, rel_vel_z, contact_radius,
        output ready
    );
endinterface

interface ssti_out_if #(
    parameter int WORD_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic [WORD_BITS-2:0] impact_time;

    modport source (output valid, hit, impact_time, input ready);
    modport sink (input valid, hit, impact_time, output ready);
endinterface

`default_nettype wire

/* rtl/core/ssti_front.sv */
// ----------------------------------------------------------------------------
// ssti_front
// Forms the quadratic coefficients, screens out misses and checks the sign
// of the discriminant over four register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ssti_front #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int QW        = 4 * WORD_BITS + 2 * FRAC_BITS + 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic signed [WORD_BITS-1:0] rel_pos_x,
    input  wire logic signed [WORD_BITS-1:0] rel_pos_y,
    input  wire logic signed [WORD_BITS-1:0] rel_pos_z,
    input  wire logic signed [WORD_BITS-1:0] rel_vel_x,
    input  wire logic signed [WORD_BITS-1:0] rel_vel_y,
    input  wire logic signed [WORD_BITS-1:0] rel_vel_z,
    input  wire logic        [WORD_BITS-2:0] contact_radius,
    output ssti_pkg::ssti_ctl_t              ctl,
    output logic             [2*WORD_BITS-1:0] coef_a,
    output logic signed      [QW-1:0]        lin,
    output logic signed      [QW-1:0]        quad
);
    import ssti_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int P2 = 2 * WORD_BITS;
    localparam int SW = 2 * WORD_BITS + 2;
    localparam int DW = 4 * WORD_BITS + 2;

    // Stage 1: coordinate products.
    logic signed [P2-1:0] pp_reg [3];
    logic signed [P2-1:0] vv_reg [3];
    logic signed [P2-1:0] pv_reg [3];
    logic signed [P2-1:0] pp_next [3];
    logic signed [P2-1:0] vv_next [3];
    logic signed [P2-1:0] pv_next [3];
    logic [P2-3:0] rr_reg, rr_next;
    logic          v1_reg, nz1_reg;

    // Stage 2: coefficients.
    logic [P2-1:0] a2_reg, a2_next;
    logic [P2-1:0] m2_reg, m2_next;
    logic [P2-1:0] c2_reg, c2_next;
    logic          v2_reg, ok2_reg, ok2_next;
    logic signed [SW-1:0] pvs, ccs;

    // Stage 3: half-word partial products of m*m and a*c.
    logic [P2-1:0] mhh_reg, mhl_reg, mll_reg, ahh_reg, ahl_reg, alh_reg, all_reg;
    logic [P2-1:0] a3_reg, m3_reg, c3_reg;
    logic          v3_reg, ok3_reg;

    // Stage 4 next values.
    logic [DW-1:0] msq, acp;
    logic          disc_ok;

    logic signed [W-1:0] pos [3];
    logic signed [W-1:0] vel [3];

    assign pos[0] = rel_pos_x;
    assign pos[1] = rel_pos_y;
    assign pos[2] = rel_pos_z;
    assign vel[0] = rel_vel_x;
    assign vel[1] = rel_vel_y;
    assign vel[2] = rel_vel_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pp_next[i] = signed'(P2'(pos[i])) * signed'(P2'(pos[i]));
            vv_next[i] = signed'(P2'(vel[i])) * signed'(P2'(vel[i]));
            pv_next[i] = signed'(P2'(pos[i])) * signed'(P2'(vel[i]));
        end
        rr_next = (P2-2)'(contact_radius) * (P2-2)'(contact_radius);
    end

    always_comb
    begin
        a2_next = P2'(vv_reg[0]) + P2'(vv_reg[1]) + P2'(vv_reg[2]);
        pvs = SW'(pv_reg[0]) + SW'(pv_reg[1]) + SW'(pv_reg[2]);
        ccs = SW'(pp_reg[0]) + SW'(pp_reg[1]) + SW'(pp_reg[2])
              - signed'(SW'(rr_reg));
        m2_next  = P2'(-pvs);
        c2_next  = P2'(ccs);
        ok2_next = nz1_reg && (a2_next != '0) && (ccs > 0) && (pvs < 0);
    end

    // The discriminant is non-negative exactly when (b/2)^2 >= a*c.
    always_comb
    begin
        msq = (DW'(mhh_reg) << P2) + (DW'(mhl_reg) << (W + 1)) + DW'(mll_reg);
        acp = (DW'(ahh_reg) << P2) + ((DW'(ahl_reg) + DW'(alh_reg)) << W)
              + DW'(all_reg);
        disc_ok = msq >= acp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            ok2_reg <= 1'b0;
            v3_reg  <= 1'b0;
            ok3_reg <= 1'b0;
            ctl     <= '0;
        end
        else if (en)
        begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            ok2_reg   <= ok2_next;
            v3_reg    <= v2_reg;
            ok3_reg   <= ok2_reg;
            ctl.valid <= v3_reg;
            ctl.ok    <= ok3_reg && disc_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg  <= pp_next;
            vv_reg  <= vv_next;
            pv_reg  <= pv_next;
            rr_reg  <= rr_next;
            nz1_reg <= contact_radius != '0;

            a2_reg <= a2_next;
            m2_reg <= m2_next;
            c2_reg <= c2_next;

            mhh_reg <= P2'(m2_reg[P2-1:W]) * P2'(m2_reg[P2-1:W]);
            mhl_reg <= P2'(m2_reg[P2-1:W]) * P2'(m2_reg[W-1:0]);
            mll_reg <= P2'(m2_reg[W-1:0])  * P2'(m2_reg[W-1:0]);
            ahh_reg <= P2'(a2_reg[P2-1:W]) * P2'(c2_reg[P2-1:W]);
            ahl_reg <= P2'(a2_reg[P2-1:W]) * P2'(c2_reg[W-1:0]);
            alh_reg <= P2'(a2_reg[W-1:0])  * P2'(c2_reg[P2-1:W]);
            all_reg <= P2'(a2_reg[W-1:0])  * P2'(c2_reg[W-1:0]);
            a3_reg  <= a2_reg;
            m3_reg  <= m2_reg;
            c3_reg  <= c2_reg;

            coef_a <= a3_reg;
            lin    <= -(signed'(QW'(m3_reg)) <<< (FRAC_BITS + 1));
            quad   <= signed'(QW'(c3_reg)) <<< (2 * FRAC_BITS);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ssti_search_stage.sv */
// ----------------------------------------------------------------------------
// ssti_search_stage
// One bit of the contact time search. Tries setting bit BIT_POS of the grid
// time and keeps it while the time stays at or before the first contact.
// ----------------------------------------------------------------------------
`default_nettype none

module ssti_search_stage #(
    parameter int WORD_BITS = 32,
    parameter int QW        = 4 * WORD_BITS + 34,
    parameter int BIT_POS   = 0
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire ssti_pkg::ssti_ctl_t           ctl_in,
    input  wire logic        [2*WORD_BITS-1:0] coef_a_in,
    input  wire logic signed [QW-1:0]          lin_in,
    input  wire logic signed [QW-1:0]          quad_in,
    input  wire logic        [WORD_BITS-2:0]   tgrid_in,
    output ssti_pkg::ssti_ctl_t                ctl_out,
    output logic             [2*WORD_BITS-1:0] coef_a_out,
    output logic signed      [QW-1:0]          lin_out,
    output logic signed      [QW-1:0]          quad_out,
    output logic             [WORD_BITS-2:0]   tgrid_out
);
    import ssti_pkg::*;

    logic signed [QW-1:0]        a_ext, lin_try, quad_try;
    logic                        take;
    logic        [WORD_BITS-2:0] tgrid_next;

    // Stepping by h = 2^BIT_POS: quad += h*lin + a*h^2, lin += 2*a*h.
    always_comb
    begin
        a_ext    = signed'(QW'(coef_a_in));
        quad_try = quad_in + (lin_in <<< BIT_POS) + (a_ext <<< (2 * BIT_POS));
        lin_try  = lin_in + (a_ext <<< (BIT_POS + 1));
        take     = (lin_try <= 0) && (quad_try >= 0);
        tgrid_next          = tgrid_in;
        tgrid_next[BIT_POS] = take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_out <= '0;
        end
        else if (en)
        begin
            ctl_out <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_a_out <= coef_a_in;
            lin_out    <= take ? lin_try : lin_in;
            quad_out   <= take ? quad_try : quad_in;
            tgrid_out  <= tgrid_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/swept_sphere_time_of_impact_core.sv */
// ----------------------------------------------------------------------------
// swept_sphere_time_of_impact_core
// Earliest contact time of two moving spheres inside one time step.
// ----------------------------------------------------------------------------
// The core takes one request per clock and returns one result per request in
// order: the front stages form the coefficients and the discriminant test,
// then a chain of search stages, each deciding one bit of the grid time,
// searches for the first contact, and one output register holds the result.
// A stall on the result side holds the whole pipeline. The contact time is the
// exact first root truncated to the Q.FRAC_BITS grid; a hit is reported only
// when it lies strictly inside (0, step_time). step_time may be rewritten only
// while the core is empty.
`default_nettype none

module swept_sphere_time_of_impact_core #(
    parameter int WORD_BITS = ssti_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = ssti_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [WORD_BITS-2:0] cfg_wr_data,
    ssti_in_if.sink                   req,
    ssti_out_if.source                rsp
);
    import ssti_pkg::*;

    localparam int QW    = 4 * WORD_BITS + 2 * FRAC_BITS + 2;
    localparam int TW    = WORD_BITS - 1;
    localparam int NSTEP = WORD_BITS - 1;

    logic [TW-1:0] step_time_reg;
    logic          en;
    logic          out_valid_reg, out_hit_reg;
    logic [TW-1:0] out_time_reg;
    logic          hit_next;

    ssti_ctl_t                ctl    [NSTEP+1];
    logic [2*WORD_BITS-1:0]   coef_a [NSTEP+1];
    logic signed [QW-1:0]     lin    [NSTEP+1];
    logic signed [QW-1:0]     quad   [NSTEP+1];
    logic [TW-1:0]            tgrid  [NSTEP+1];

    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg <= TW'(STEP_RESET);
        end
        else if (cfg_wr_en)
        begin
            step_time_reg <= cfg_wr_data;
        end
    end

    ssti_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (req.valid),
        .rel_pos_x      (req.rel_pos_x),
        .rel_pos_y      (req.rel_pos_y),
        .rel_pos_z      (req.rel_pos_z),
        .rel_vel_x      (req.rel_vel_x),
        .rel_vel_y      (req.rel_vel_y),
        .rel_vel_z      (req.rel_vel_z),
        .contact_radius (req.contact_radius),
        .ctl            (ctl[0]),
        .coef_a         (coef_a[0]),
        .lin            (lin[0]),
        .quad           (quad[0])
    );

    assign tgrid[0] = '0;

    // Stage i decides bit NSTEP-1-i, most significant first.
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_search
        ssti_search_stage #(
            .WORD_BITS (WORD_BITS),
            .QW        (QW),
            .BIT_POS   (NSTEP - 1 - i)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .en         (en),
            .ctl_in     (ctl[i]),
            .coef_a_in  (coef_a[i]),
            .lin_in     (lin[i]),
            .quad_in    (quad[i]),
            .tgrid_in   (tgrid[i]),
            .ctl_out    (ctl[i+1]),
            .coef_a_out (coef_a[i+1]),
            .lin_out    (lin[i+1]),
            .quad_out   (quad[i+1]),
            .tgrid_out  (tgrid[i+1])
        );
    end

    // The search saturates at all ones, which never lies below a legal step.
    assign hit_next = ctl[NSTEP].ok && (tgrid[NSTEP] < step_time_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl[NSTEP].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg  <= hit_next;
            out_time_reg <= hit_next ? tgrid[NSTEP] : '0;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.impact_time = out_time_reg;

endmodule

`default_nettype wire

/* dv/ssti_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssti_tb_if
// Test bench side view of the request and result channels. The core's own
// channel interfaces are instantiated directly by the bench top; this file
// holds the shared item and result types used by the bench.
// ----------------------------------------------------------------------------

package ssti_tb_pkg;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic        [30:0] radius;
    } body_pair_t;

    typedef struct {
        logic        hit;
        logic [30:0] impact_time;
    } impact_t;

endpackage

/* dv/swept_sphere_time_of_impact_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// swept_sphere_time_of_impact_core_tb
// Drives body pairs into the core under several step lengths, predicts the
// exact first contact time with wide integer arithmetic and checks every
// result in order, with random idling on both channels.
// ----------------------------------------------------------------------------

module swept_sphere_time_of_impact_core_tb;

    import ssti_tb_pkg::*;

    typedef logic signed [319:0] wide_t;

    localparam int LATENCY     = 36;
    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 90;
    localparam int LONG_HOLD   = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [30:0] cfg_wr_data;

    ssti_in_if  #(.WORD_BITS(32)) req_if ();
    ssti_out_if #(.WORD_BITS(32)) rsp_if ();

    swept_sphere_time_of_impact_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_if.sink),
        .rsp         (rsp_if.source)
    );

    body_pair_t  pending_pairs[$];
    impact_t     expected_impacts[$];
    body_pair_t  offered_pair;
    logic [30:0] step_len;
    int          mismatches;
    int          results_seen;
    int          idle_cycles;
    int          send_gap;
    int          recv_gap;
    int          hold_count;
    bit          hold_done;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // True while grid time t is still at or before the earlier root.
    function automatic bit still_apart(longint unsigned t, wide_t a, wide_t a2,
                                       wide_t bs, wide_t cs);
        wide_t tw;
        wide_t lin;
        wide_t quad;
        tw  = t;
        lin = a2 * tw + bs;
        if (lin > 0)
            return 1'b0;
        quad = a * tw * tw + bs * tw + cs;
        return quad >= 0;
    endfunction

    function automatic impact_t first_contact(body_pair_t p, logic [30:0] step);
        impact_t         res;
        wide_t           dx, dy, dz, vx, vy, vz, r, a, b, c, disc, a2, bs, cs;
        longint unsigned lo, hi, mid;
        res.hit         = 1'b0;
        res.impact_time = '0;
        if (p.radius == 0 || step == 0)
            return res;
        dx = p.pos_x; dy = p.pos_y; dz = p.pos_z;
        vx = p.vel_x; vy = p.vel_y; vz = p.vel_z;
        r  = {289'd0, p.radius};
        a  = vx * vx + vy * vy + vz * vz;
        b  = 2 * (dx * vx + dy * vy + dz * vz);
        c  = dx * dx + dy * dy + dz * dz - r * r;
        if (a <= 0 || c <= 0 || b >= 0)
            return res;
        disc = b * b - 4 * a * c;
        if (disc < 0)
            return res;
        a2 = 2 * a;
        bs = b * 65536;
        cs = c * 65536 * 65536;
        if (still_apart(step, a, a2, bs, cs))
            return res;
        lo = 0;
        hi = step;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (still_apart(mid, a, a2, bs, cs))
                lo = mid;
            else
                hi = mid;
        end
        res.hit         = 1'b1;
        res.impact_time = lo[30:0];
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Pair on a closing course with random content; a quarter is pure noise.
    function automatic body_pair_t closing_pair(logic [30:0] step);
        body_pair_t      p;
        longint          px, py, pz, tgt, span, maxabs;
        longint unsigned lim;
        if ($urandom_range(0, 3) == 0)
        begin
            p.pos_x  = $urandom; p.pos_y = $urandom; p.pos_z = $urandom;
            p.vel_x  = $urandom; p.vel_y = $urandom; p.vel_z = $urandom;
            p.radius = 31'($urandom);
            return p;
        end
        px = longint'($urandom_range(0, (1 << $urandom_range(1, 30)) - 1));
        py = longint'($urandom_range(0, (1 << $urandom_range(1, 30)) - 1));
        pz = longint'($urandom_range(0, (1 << $urandom_range(1, 30)) - 1));
        if ($urandom_range(0, 1)) px = -px;
        if ($urandom_range(0, 1)) py = -py;
        if ($urandom_range(0, 1)) pz = -pz;
        lim  = 2 * longint'(step);
        if (lim > 64'd1048576)
            lim = 64'd1048576;
        if (lim < 2)
            lim = 2;
        tgt  = longint'($urandom_range(1, int'(lim)));
        p.pos_x = 32'(px); p.pos_y = 32'(py); p.pos_z = 32'(pz);
        p.vel_x = clamp32(-(px * 65536) / tgt + int'($urandom_range(0, 255)) - 128);
        p.vel_y = clamp32(-(py * 65536) / tgt + int'($urandom_range(0, 255)) - 128);
        p.vel_z = clamp32(-(pz * 65536) / tgt + int'($urandom_range(0, 255)) - 128);
        maxabs = px < 0 ? -px : px;
        span   = py < 0 ? -py : py;
        if (span > maxabs) maxabs = span;
        span   = pz < 0 ? -pz : pz;
        if (span > maxabs) maxabs = span;
        if (maxabs < 1) maxabs = 1;
        p.radius = 31'($urandom_range(1, int'(maxabs)));
        return p;
    endfunction

    function automatic body_pair_t make_pair(longint px, longint py, longint pz,
                                             longint vx, longint vy, longint vz,
                                             longint rad);
        body_pair_t p;
        p.pos_x = 32'(px); p.pos_y = 32'(py); p.pos_z = 32'(pz);
        p.vel_x = 32'(vx); p.vel_y = 32'(vy); p.vel_z = 32'(vz);
        p.radius = 31'(rad);
        return p;
    endfunction

    // Request driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid          <= 1'b0;
            req_if.rel_pos_x      <= '0;
            req_if.rel_pos_y      <= '0;
            req_if.rel_pos_z      <= '0;
            req_if.rel_vel_x      <= '0;
            req_if.rel_vel_y      <= '0;
            req_if.rel_vel_z      <= '0;
            req_if.contact_radius <= '0;
            send_gap              <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
                expected_impacts.push_back(first_contact(offered_pair, step_len));
            if (req_if.valid && !req_if.ready)
            begin
                // Hold the offered request until it is taken.
            end
            else if (send_gap > 0)
            begin
                send_gap     <= send_gap - 1;
                req_if.valid <= 1'b0;
            end
            else if (pending_pairs.size() > 0)
            begin
                offered_pair = pending_pairs.pop_front();
                req_if.valid          <= 1'b1;
                req_if.rel_pos_x      <= offered_pair.pos_x;
                req_if.rel_pos_y      <= offered_pair.pos_y;
                req_if.rel_pos_z      <= offered_pair.pos_z;
                req_if.rel_vel_x      <= offered_pair.vel_x;
                req_if.rel_vel_y      <= offered_pair.vel_y;
                req_if.rel_vel_z      <= offered_pair.vel_z;
                req_if.contact_radius <= offered_pair.radius;
                send_gap              <= pick_gap();
            end
            else
                req_if.valid <= 1'b0;
        end
    end

    // Result monitor and checker.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            recv_gap     <= 0;
            hold_count   <= 0;
            hold_done    <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_impacts.size() == 0)
                begin
                    $display("%0t: unexpected result hit=%0b time=%0d", $time,
                             rsp_if.hit, rsp_if.impact_time);
                    mismatches++;
                end
                else
                begin
                    impact_t want;
                    want = expected_impacts.pop_front();
                    if (rsp_if.hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0b actual %0b", $time,
                                 want.hit, rsp_if.hit);
                        mismatches++;
                    end
                    if (rsp_if.impact_time !== want.impact_time)
                    begin
                        $display("%0t: impact_time expected %0d actual %0d", $time,
                                 want.impact_time, rsp_if.impact_time);
                        mismatches++;
                    end
                end
            end
            // One long hold-off so the pipeline fills and stalls the input.
            if (!hold_done && results_seen >= 60)
            begin
                rsp_if.ready <= 1'b0;
                hold_count   <= hold_count + 1;
                if (hold_count >= LONG_HOLD)
                    hold_done <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap     <= recv_gap - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                recv_gap     <= pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("swept_sphere_time_of_impact_core verification failed");
            $finish;
        end
    end

    // Checked on the falling edge so that all updates of the rising edge
    // have settled.
    task automatic drain();
        @(negedge clk);
        while (pending_pairs.size() > 0 || req_if.valid || expected_impacts.size() > 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_step(logic [30:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        step_len    = value;
    endtask

    initial
    begin
        logic [30:0] steps[5];
        step_len    = 31'd1092;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset step length.
        pending_pairs.push_back(make_pair(10 <<< 16, 0, 0, -(1000 <<< 16), 0, 0, 0));
        pending_pairs.push_back(make_pair(10 <<< 16, 0, 0, 0, 0, 0, 1 <<< 16));
        pending_pairs.push_back(make_pair(1 <<< 16, 0, 0, -(1 <<< 16), 0, 0, 2 <<< 16));
        pending_pairs.push_back(make_pair(1 <<< 16, 0, 0, -(1 <<< 16), 0, 0, 1 <<< 16));
        pending_pairs.push_back(make_pair(10 <<< 16, 0, 0, 1000 <<< 16, 0, 0, 1 <<< 16));
        pending_pairs.push_back(make_pair(10 <<< 16, 0, 0, 0, 1000 <<< 16, 0, 1 <<< 16));
        pending_pairs.push_back(make_pair(10 <<< 16, 5 <<< 16, 0, -(1000 <<< 16), 0, 0,
                                          1 <<< 16));
        pending_pairs.push_back(make_pair(2 <<< 16, 0, 0, -2147483647, 0, 0,
                                          (2 <<< 16) - 1));
        pending_pairs.push_back(make_pair(10 <<< 16, 0, 0, -(1000 <<< 16), 0, 0,
                                          1 <<< 16));
        pending_pairs.push_back(make_pair(0, -(10 <<< 16), 3 <<< 16, 0, 2000 <<< 16,
                                          -(600 <<< 16), 1 <<< 16));
        pending_pairs.push_back(make_pair(-2147483648, -2147483648, -2147483648,
                                          2147483647, 2147483647, 2147483647, 2147483647));
        pending_pairs.push_back(make_pair(2147483647, 2147483647, 2147483647,
                                          -2147483648, -2147483648, -2147483648,
                                          2147483647));
        pending_pairs.push_back(make_pair(-2147483648, -2147483648, -2147483648,
                                          -2147483648, -2147483648, -2147483648, 1));
        pending_pairs.push_back(make_pair(2147483647, 2147483647, 2147483647,
                                          2147483647, 2147483647, 2147483647, 2147483647));
        pending_pairs.push_back(make_pair(100, 0, 0, -2147483648, 0, 0, 1));

        steps[0] = 31'd1092;
        steps[1] = 31'd1;
        steps[2] = 31'h7fffffff;
        steps[3] = 31'd65536;
        steps[4] = 31'($urandom_range(2, 200000));
        foreach (steps[i])
        begin
            if (i > 0)
            begin
                drain();
                write_step(steps[i]);
            end
            repeat (PHASE_ITEMS) pending_pairs.push_back(closing_pair(step_len));
        end
        drain();

        if (mismatches == 0)
            $display("swept_sphere_time_of_impact_core verification clean");
        else
            $display("swept_sphere_time_of_impact_core verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ssti_pkg.sv
rtl/core/ssti_if.sv
rtl/core/ssti_front.sv
rtl/core/ssti_search_stage.sv
rtl/core/swept_sphere_time_of_impact_core.sv
dv/ssti_tb_if.sv
dv/swept_sphere_time_of_impact_core_tb.sv
